>>> sv/mfdi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mfdi_pkg
// Shared widths, constants and types of the meter frame demand integrator.
// ============================================================================
package mfdi_pkg;

    // Window geometry and the widths that follow from it.
    localparam int WINDOW_SLOTS = 15;
    localparam int ADDR_W       = $clog2(WINDOW_SLOTS);
    localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W        = 16 + $clog2(WINDOW_SLOTS);

    // Scaling datapath.
    localparam int SCALE_W      = 24;
    localparam int SCALE_HALF_W = 12;
    localparam int PROD_W       = SUM_W + SCALE_HALF_W;
    localparam int WIDE_W       = (SUM_W + SCALE_W > 44) ? SUM_W + SCALE_W : 44;
    localparam int TOTAL_W      = 32;
    localparam int TOTAL_SHIFT  = 11;
    localparam int PHASE_W      = 16;

    // Divide by three, a few quotient bits per cycle.
    localparam int DIV3_BITS    = 4;
    localparam int DIV3_STEPS   = TOTAL_W / DIV3_BITS;
    localparam int DIV3_CNT_W   = $clog2(DIV3_STEPS);
    localparam logic [2:0] DIV3_DIVISOR = 3'd3;

    // Minute index: seconds elapsed divided by 60 through a reciprocal.
    localparam int IDX_W = 8;
    localparam logic [15:0] INTERVAL_SECONDS = 16'd900;
    localparam logic [15:0] DIV60_MULT       = 16'd34953;
    localparam int DIV60_SHIFT = 21;

    // Seconds-left marks for minute snapping and the pulse snapshot.
    localparam logic [11:0] SNAP_SECS_FIVE = 12'd600;
    localparam logic [11:0] SNAP_SECS_TEN  = 12'd300;
    localparam logic [11:0] SNAP_SECS_END  = 12'd0;
    localparam logic [11:0] SNAPSHOT_SECS_A = 12'd2;
    localparam logic [11:0] SNAPSHOT_SECS_B = 12'd3;

    // Tariff debounce length in frames.
    localparam logic [3:0] DEBOUNCE_FRAMES = 4'd10;

    // Configuration registers.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic REG_ACTIVE_SCALE   = 1'b0;
    localparam logic REG_REACTIVE_SCALE = 1'b1;

    // One window slot holds both energy lanes.
    typedef struct packed {
        logic [15:0] active;
        logic [15:0] reactive;
    } t_slot;

    // Decoded view of one frame.
    typedef struct packed {
        logic        chk_ok;
        logic        billing;
        logic        capacitive;
        logic        inductive;
        logic        snapshot;
        logic [5:0]  minute_out;
        logic [14:0] active_pulses;
        logic [14:0] reactive_pulses;
        logic [15:0] idx_num;
    } t_frame_info;

    // Sequencer strobes to one scaling lane.
    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic div_step;
    } t_lane_ctrl;

endpackage

>>> sv/mfdi_frame_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// mfdi_frame_decode
// Checks a meter frame, unpacks its fields and snaps the minute.
// ============================================================================
module mfdi_frame_decode
    import mfdi_pkg::*;
(
    input  logic [7:0]  i_seconds_low,
    input  logic [7:0]  i_flags_seconds_high,
    input  logic [7:0]  i_tariff_post_byte,
    input  logic [7:0]  i_active_pulses_low,
    input  logic [7:0]  i_active_pulses_high,
    input  logic [7:0]  i_reactive_pulses_low,
    input  logic [7:0]  i_reactive_pulses_high,
    input  logic [7:0]  i_check_byte,
    input  logic [5:0]  i_current_minute,
    output t_frame_info o_info
);

    logic [7:0]  chk;
    logic        chk_ok;
    logic [11:0] secs;
    logic [5:0]  snapped;

    function automatic logic in_rng(input logic [5:0] m, input logic [5:0] lo,
                                    input logic [5:0] hi);
        return (m >= lo) && (m <= hi);
    endfunction

    // The check byte is the inverted XOR of the seven bytes before it.
    assign chk = ~(i_seconds_low ^ i_flags_seconds_high ^ i_tariff_post_byte ^
                   i_active_pulses_low ^ i_active_pulses_high ^
                   i_reactive_pulses_low ^ i_reactive_pulses_high);
    assign chk_ok = (chk == i_check_byte);
    assign secs   = {i_flags_seconds_high[3:0], i_seconds_low};

    // Snap the minute to a multiple of five at the three seconds-left marks.
    always_comb begin
        snapped = i_current_minute;
        if (secs == SNAP_SECS_FIVE) begin
            if (in_rng(i_current_minute, 6'd3, 6'd7))        snapped = 6'd5;
            else if (in_rng(i_current_minute, 6'd18, 6'd22)) snapped = 6'd20;
            else if (in_rng(i_current_minute, 6'd33, 6'd37)) snapped = 6'd35;
            else if (in_rng(i_current_minute, 6'd43, 6'd47)) snapped = 6'd45;
        end else if (secs == SNAP_SECS_TEN) begin
            if (in_rng(i_current_minute, 6'd8, 6'd12))       snapped = 6'd10;
            else if (in_rng(i_current_minute, 6'd23, 6'd27)) snapped = 6'd25;
            else if (in_rng(i_current_minute, 6'd38, 6'd42)) snapped = 6'd40;
            else if (in_rng(i_current_minute, 6'd53, 6'd57)) snapped = 6'd55;
        end else if (secs == SNAP_SECS_END) begin
            if (i_current_minute < 6'd3)                     snapped = 6'd0;
            else if (in_rng(i_current_minute, 6'd13, 6'd17)) snapped = 6'd15;
            else if (in_rng(i_current_minute, 6'd28, 6'd32)) snapped = 6'd30;
            else if (in_rng(i_current_minute, 6'd43, 6'd47)) snapped = 6'd45;
        end
    end

    // Flags read as zero and the minute passes raw on a bad frame.
    always_comb begin
        o_info.chk_ok          = chk_ok;
        o_info.billing         = chk_ok & i_flags_seconds_high[4];
        o_info.capacitive      = chk_ok & i_flags_seconds_high[6];
        o_info.inductive       = chk_ok & i_flags_seconds_high[7];
        o_info.snapshot        = chk_ok & ((secs == SNAPSHOT_SECS_A) ||
                                           (secs == SNAPSHOT_SECS_B));
        o_info.minute_out      = chk_ok ? snapped : i_current_minute;
        o_info.active_pulses   = {i_active_pulses_high[6:0], i_active_pulses_low};
        o_info.reactive_pulses = {i_reactive_pulses_high[6:0], i_reactive_pulses_low};
        o_info.idx_num         = 16'(INTERVAL_SECONDS - {4'b0, secs});
    end

endmodule

>>> sv/mfdi_window_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// mfdi_window_mem
// Demand window store: one slot per minute, both lanes in one word.
// ============================================================================
module mfdi_window_mem
    import mfdi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_slot             o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_slot             i_wr_data
);

    t_slot                   r_mem [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0] r_valid;
    t_slot                   r_rd_data;
    logic                    r_rd_valid;

    // Synchronous write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits make a cleared slot read as zero without a sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

`ifndef SYNTH
    a_no_rw_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("window read and write hit the same slot");
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |-> (!i_wr_en && !i_rd_en))
        else $error("window clear overlaps an access");
    a_rd_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> (i_rd_addr <= ADDR_W'(WINDOW_SLOTS - 1)))
        else $error("window read beyond last slot");
`endif

endmodule

>>> sv/mfdi_scale_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// mfdi_scale_lane
// Scales one window sum by a Q8.16 gain times 32, saturates, divides by 3.
// ============================================================================
module mfdi_scale_lane
    import mfdi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctrl         i_ctrl,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [SCALE_W-1:0] i_scale,
    output logic [TOTAL_W-1:0] o_total,
    output logic [PHASE_W-1:0] o_per_phase
);

    logic [PROD_W-1:0]    r_prod_lo;
    logic [PROD_W-1:0]    r_prod_hi;
    logic [WIDE_W-1:0]    wide;
    logic                 sat;
    logic [TOTAL_W-1:0]   sat_total;
    logic [TOTAL_W-1:0]   r_total;
    logic [TOTAL_W-1:0]   r_div_src;
    logic [1:0]           r_div_rem;
    logic [1:0]           rem;
    logic [2:0]           trial;
    logic [DIV3_BITS-1:0] quot_bits;
    logic [PHASE_W-1:0]   r_phase;

    // Join the two partial products and drop the Q16 fraction less the x32.
    always_comb begin
        wide      = (WIDE_W'(r_prod_hi) << SCALE_HALF_W) + WIDE_W'(r_prod_lo);
        sat       = |wide[WIDE_W-1:TOTAL_W+TOTAL_SHIFT];
        sat_total = sat ? '1 : wide[TOTAL_SHIFT +: TOTAL_W];
    end

    // Restoring division by three over the next few bits, MSB first.
    always_comb begin
        rem = r_div_rem;
        for (int k = 0; k < DIV3_BITS; k++) begin
            trial = {rem, r_div_src[TOTAL_W-1-k]};
            if (trial >= DIV3_DIVISOR) begin
                quot_bits[DIV3_BITS-1-k] = 1'b1;
                rem = 2'(trial - DIV3_DIVISOR);
            end else begin
                quot_bits[DIV3_BITS-1-k] = 1'b0;
                rem = trial[1:0];
            end
        end
    end

    // Held total and per-phase value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_phase <= '0;
        end else begin
            if (i_ctrl.combine) begin
                r_total <= sat_total;
            end
            if (i_ctrl.div_step) begin
                r_phase <= {r_phase[PHASE_W-1-DIV3_BITS:0], quot_bits};
            end
        end
    end

    // Partial products and divider working registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_lo) begin
            r_prod_lo <= PROD_W'(i_sum) * PROD_W'(i_scale[SCALE_HALF_W-1:0]);
        end
        if (i_ctrl.mul_hi) begin
            r_prod_hi <= PROD_W'(i_sum) * PROD_W'(i_scale[SCALE_W-1:SCALE_HALF_W]);
        end
        if (i_ctrl.combine) begin
            r_div_src <= sat_total;
            r_div_rem <= 2'b0;
        end else if (i_ctrl.div_step) begin
            r_div_src <= r_div_src << DIV3_BITS;
            r_div_rem <= rem;
        end
    end

    assign o_total     = r_total;
    assign o_per_phase = r_phase;

endmodule

>>> sv/meter_frame_demand_integrator.sv
// Order: an accepted item is checked and decoded and its minute index formed;
// a new minute index in range then sweeps the window, multiplies and divides.
// Throughput: one item at a time; the window sweep (one slot read and written
// back per cycle) is followed by the low and high multiply and eight-step divide.
// Reset: synchronous, active low; windows read as zero and the gains load 1.0.
`timescale 1ns / 1ps
// ============================================================================
// meter_frame_demand_integrator
// Checks meter frames, tracks per-minute energy in a demand window and
// gives the scaled window totals.
// ============================================================================
module meter_frame_demand_integrator
    import mfdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input item.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_seconds_low,
    input  logic [7:0]  i_flags_seconds_high,
    input  logic [7:0]  i_tariff_post_byte,
    input  logic [7:0]  i_active_pulses_low,
    input  logic [7:0]  i_active_pulses_high,
    input  logic [7:0]  i_reactive_pulses_low,
    input  logic [7:0]  i_reactive_pulses_high,
    input  logic [7:0]  i_check_byte,
    input  logic [5:0]  i_current_minute,
    // Result item.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_checksum_error,
    output logic        o_billing_flag,
    output logic        o_capacitive_tariff,
    output logic        o_inductive_tariff,
    output logic [5:0]  o_minute_out,
    output logic        o_window_cleared,
    output logic        o_slot_updated,
    output logic        o_snapshot_taken,
    output logic [31:0] o_active_total,
    output logic [31:0] o_reactive_total,
    output logic [15:0] o_active_per_phase,
    output logic [15:0] o_reactive_per_phase
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_IDX    = 4'd2;
    localparam logic [3:0] S_SWEEP  = 4'd3;
    localparam logic [3:0] S_MUL_LO = 4'd4;
    localparam logic [3:0] S_MUL_HI = 4'd5;
    localparam logic [3:0] S_COMB   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]            r_state;
    logic [3:0]            n_state;

    // Captured frame.
    logic [7:0]            r_seconds_low;
    logic [7:0]            r_flags_seconds_high;
    logic [7:0]            r_tariff_post_byte;
    logic [7:0]            r_active_pulses_low;
    logic [7:0]            r_active_pulses_high;
    logic [7:0]            r_reactive_pulses_low;
    logic [7:0]            r_reactive_pulses_high;
    logic [7:0]            r_check_byte;
    logic [5:0]            r_current_minute;
    t_frame_info           info;

    // Frame history.
    logic [IDX_W-1:0]      r_last_idx;
    logic [14:0]           r_last_pa;
    logic [14:0]           r_last_pr;
    logic [15:0]           r_last_ea;
    logic [15:0]           r_last_er;
    logic [3:0]            r_tariff_cnt;
    logic [3:0]            n_tariff_cnt;
    logic                  r_last_ind;
    logic                  n_last_ind;
    logic                  deb_clear;

    // Minute index and deltas.
    logic [31:0]           r_idx_prod;
    logic [IDX_W-1:0]      idx_now;
    logic                  idx_new;
    logic                  idx_in_range;
    logic [IDX_W-1:0]      r_idx;
    logic [15:0]           delta_a;
    logic [15:0]           delta_r;
    logic [15:0]           r_delta_a;
    logic [15:0]           r_delta_r;
    logic                  r_cleared;
    logic                  r_updated;

    // Window sweep.
    logic [CNT_W-1:0]      r_cnt;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    t_slot                 rd_data;
    logic                  r_wb_pend;
    logic [ADDR_W-1:0]     r_wb_addr;
    logic [IDX_W-1:0]      wb_idx;
    logic                  wb_hit;
    logic                  wb_tail;
    logic                  wr_en;
    t_slot                 wb_data;
    logic [SUM_W-1:0]      r_sum_a;
    logic [SUM_W-1:0]      r_sum_r;
    logic                  mem_clear;

    // Scaling.
    t_lane_ctrl            lane_ctrl;
    logic [DIV3_CNT_W-1:0] r_div_cnt;
    logic [TOTAL_W-1:0]    act_total;
    logic [TOTAL_W-1:0]    react_total;
    logic [PHASE_W-1:0]    act_phase;
    logic [PHASE_W-1:0]    react_phase;

    // Configuration and output register.
    logic [SCALE_W-1:0]    r_active_scale;
    logic [SCALE_W-1:0]    r_reactive_scale;
    logic                  cfg_wr;
    logic                  accept;
    logic                  out_free;
    logic                  r_out_valid;
    logic                  r_o_checksum_error;
    logic                  r_o_billing_flag;
    logic                  r_o_capacitive_tariff;
    logic                  r_o_inductive_tariff;
    logic [5:0]            r_o_minute_out;
    logic                  r_o_window_cleared;
    logic                  r_o_slot_updated;
    logic                  r_o_snapshot_taken;
    logic [31:0]           r_o_active_total;
    logic [31:0]           r_o_reactive_total;
    logic [15:0]           r_o_active_per_phase;
    logic [15:0]           r_o_reactive_per_phase;

    mfdi_frame_decode u_decode (
        .i_seconds_low          (r_seconds_low),
        .i_flags_seconds_high   (r_flags_seconds_high),
        .i_tariff_post_byte     (r_tariff_post_byte),
        .i_active_pulses_low    (r_active_pulses_low),
        .i_active_pulses_high   (r_active_pulses_high),
        .i_reactive_pulses_low  (r_reactive_pulses_low),
        .i_reactive_pulses_high (r_reactive_pulses_high),
        .i_check_byte           (r_check_byte),
        .i_current_minute       (r_current_minute),
        .o_info                 (info)
    );

    // Configuration registers; the APB port never stalls.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_ACTIVE_SCALE:   prdata = {8'b0, r_active_scale};
            REG_REACTIVE_SCALE: prdata = {8'b0, r_reactive_scale};
            default:            prdata = '0;
        endcase
    end

    // Handshakes.
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Tariff debounce: a confirmed change of the inductive bit clears the window.
    always_comb begin
        n_tariff_cnt = r_tariff_cnt;
        n_last_ind   = r_last_ind;
        deb_clear    = 1'b0;
        if (info.inductive != r_last_ind) begin
            n_tariff_cnt = r_tariff_cnt + 4'd1;
            if (n_tariff_cnt == DEBOUNCE_FRAMES) begin
                n_tariff_cnt = 4'd0;
                deb_clear    = 1'b1;
            end
        end else begin
            n_tariff_cnt = 4'd0;
        end
        if (n_tariff_cnt == 4'd0) begin
            n_last_ind = info.inductive;
        end
    end

    // Minute index from the registered reciprocal product, and pulse deltas.
    always_comb begin
        idx_now      = r_idx_prod[DIV60_SHIFT +: IDX_W];
        idx_new      = (idx_now != r_last_idx);
        idx_in_range = (idx_now < IDX_W'(WINDOW_SLOTS));
        if (info.active_pulses > r_last_pa) begin
            delta_a = {1'b0, 15'(info.active_pulses - r_last_pa)};
        end else if (info.active_pulses < r_last_pa) begin
            delta_a = r_last_ea;
        end else begin
            delta_a = '0;
        end
        if (info.reactive_pulses > r_last_pr) begin
            delta_r = {1'b0, 15'(info.reactive_pulses - r_last_pr)};
        end else if (info.reactive_pulses < r_last_pr) begin
            delta_r = r_last_er;
        end else begin
            delta_r = '0;
        end
    end

    // Sweep: read slot n while slot n-1 is modified and written back.
    always_comb begin
        rd_en   = (r_state == S_SWEEP) && (r_cnt < CNT_W'(WINDOW_SLOTS));
        rd_addr = r_cnt[ADDR_W-1:0];
        wr_en   = (r_state == S_SWEEP) && r_wb_pend;
        wb_idx  = {{(IDX_W - ADDR_W){1'b0}}, r_wb_addr};
        wb_hit  = (wb_idx == r_idx);
        wb_tail = (r_wb_addr == '0) || (wb_idx >= r_idx);
        wb_data.active   = (wb_hit || ((r_delta_a != '0) && wb_tail)) ?
                           r_delta_a : rd_data.active;
        wb_data.reactive = (wb_hit || ((r_delta_r != '0) && wb_tail)) ?
                           r_delta_r : rd_data.reactive;
        mem_clear = (r_state == S_DEC) && info.chk_ok && deb_clear;
    end

    mfdi_window_mem u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (mem_clear),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wb_addr),
        .i_wr_data (wb_data)
    );

    // Lane strobes.
    always_comb begin
        lane_ctrl.mul_lo   = (r_state == S_MUL_LO);
        lane_ctrl.mul_hi   = (r_state == S_MUL_HI);
        lane_ctrl.combine  = (r_state == S_COMB);
        lane_ctrl.div_step = (r_state == S_DIV);
    end

    mfdi_scale_lane u_active_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (lane_ctrl),
        .i_sum       (r_sum_a),
        .i_scale     (r_active_scale),
        .o_total     (act_total),
        .o_per_phase (act_phase)
    );

    mfdi_scale_lane u_reactive_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (lane_ctrl),
        .i_sum       (r_sum_r),
        .i_scale     (r_reactive_scale),
        .o_total     (react_total),
        .o_per_phase (react_phase)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC:    n_state = info.chk_ok ? S_IDX : S_OUT;
            S_IDX:    n_state = (idx_new && idx_in_range) ? S_SWEEP : S_OUT;
            S_SWEEP: begin
                if (r_cnt == CNT_W'(WINDOW_SLOTS)) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_COMB;
            S_COMB:   n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == DIV3_CNT_W'(DIV3_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control and history registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_last_idx       <= '0;
            r_last_pa        <= '0;
            r_last_pr        <= '0;
            r_last_ea        <= '0;
            r_last_er        <= '0;
            r_tariff_cnt     <= '0;
            r_last_ind       <= 1'b0;
            r_cleared        <= 1'b0;
            r_updated        <= 1'b0;
            r_cnt            <= '0;
            r_wb_pend        <= 1'b0;
            r_div_cnt        <= '0;
            r_out_valid      <= 1'b0;
            r_active_scale   <= SCALE_RESET;
            r_reactive_scale <= SCALE_RESET;
        end else begin
            r_state   <= n_state;
            r_wb_pend <= rd_en;

            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ACTIVE_SCALE:   r_active_scale   <= pwdata[SCALE_W-1:0];
                    REG_REACTIVE_SCALE: r_reactive_scale <= pwdata[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_DEC) begin
                r_updated <= 1'b0;
                r_cleared <= info.chk_ok && deb_clear;
                if (info.chk_ok) begin
                    r_tariff_cnt <= n_tariff_cnt;
                    r_last_ind   <= n_last_ind;
                end
            end

            if ((r_state == S_IDX) && idx_new) begin
                r_last_idx <= idx_now;
                r_last_pa  <= info.active_pulses;
                r_last_pr  <= info.reactive_pulses;
                r_last_ea  <= delta_a;
                r_last_er  <= delta_r;
                if (idx_in_range) begin
                    r_updated <= 1'b1;
                    r_cnt     <= '0;
                end
            end

            if (rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (r_state == S_COMB) begin
                r_div_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + DIV3_CNT_W'(1);
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seconds_low          <= i_seconds_low;
            r_flags_seconds_high   <= i_flags_seconds_high;
            r_tariff_post_byte     <= i_tariff_post_byte;
            r_active_pulses_low    <= i_active_pulses_low;
            r_active_pulses_high   <= i_active_pulses_high;
            r_reactive_pulses_low  <= i_reactive_pulses_low;
            r_reactive_pulses_high <= i_reactive_pulses_high;
            r_check_byte           <= i_check_byte;
            r_current_minute       <= i_current_minute;
        end

        if (r_state == S_DEC) begin
            r_idx_prod <= {16'b0, info.idx_num} * {16'b0, DIV60_MULT};
        end

        if (r_state == S_IDX) begin
            r_idx     <= idx_now;
            r_delta_a <= delta_a;
            r_delta_r <= delta_r;
            r_sum_a   <= '0;
            r_sum_r   <= '0;
        end

        if (rd_en) begin
            r_wb_addr <= rd_addr;
        end

        if (wr_en) begin
            r_sum_a <= r_sum_a + SUM_W'(wb_data.active);
            r_sum_r <= r_sum_r + SUM_W'(wb_data.reactive);
        end

        if ((r_state == S_OUT) && out_free) begin
            r_o_checksum_error     <= !info.chk_ok;
            r_o_billing_flag       <= info.billing;
            r_o_capacitive_tariff  <= info.capacitive;
            r_o_inductive_tariff   <= info.inductive;
            r_o_minute_out         <= info.minute_out;
            r_o_window_cleared     <= r_cleared;
            r_o_slot_updated       <= r_updated;
            r_o_snapshot_taken     <= info.snapshot;
            r_o_active_total       <= act_total;
            r_o_reactive_total     <= react_total;
            r_o_active_per_phase   <= act_phase;
            r_o_reactive_per_phase <= react_phase;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_checksum_error     = r_o_checksum_error;
    assign o_billing_flag       = r_o_billing_flag;
    assign o_capacitive_tariff  = r_o_capacitive_tariff;
    assign o_inductive_tariff   = r_o_inductive_tariff;
    assign o_minute_out         = r_o_minute_out;
    assign o_window_cleared     = r_o_window_cleared;
    assign o_slot_updated       = r_o_slot_updated;
    assign o_snapshot_taken     = r_o_snapshot_taken;
    assign o_active_total       = r_o_active_total;
    assign o_reactive_total     = r_o_reactive_total;
    assign o_active_per_phase   = r_o_active_per_phase;
    assign o_reactive_per_phase = r_o_reactive_per_phase;

`ifndef SYNTH
    a_debounce_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tariff_cnt < DEBOUNCE_FRAMES)
        else $error("tariff debounce count passed its limit");
    a_writeback_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> $past(rd_en))
        else $error("window write-back without a preceding read");
    a_update_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_updated) |-> (r_idx < IDX_W'(WINDOW_SLOTS)))
        else $error("slot update reported for an index outside the window");
`endif

endmodule
